[rtl/core/u8esc_pkg.sv]
// Package for the UTF-8 validating byte escaper core.
// Holds the result record type, byte constants and result kind codes.
// Has no dependencies.
package u8esc_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);
  localparam int unsigned IdxW       = $clog2(MaxResults);

  localparam logic KIND_LIT = 1'b0;
  localparam logic KIND_ESC = 1'b1;

  localparam logic [7:0] BYTE_CR      = 8'h0D;
  localparam logic [7:0] BYTE_LF      = 8'h0A;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_DEL     = 8'h7F;
  localparam logic [7:0] BYTE_CONT_LO = 8'h80;
  localparam logic [7:0] BYTE_CONT_HI = 8'hBF;
  localparam logic [7:0] BYTE_LEAD_LO = 8'hC2;
  localparam logic [7:0] BYTE_LEAD2HI = 8'hDF;
  localparam logic [7:0] BYTE_LEAD3HI = 8'hEF;
  localparam logic [7:0] BYTE_BAD_LO  = 8'hF5;
  localparam logic [7:0] BYTE_E0      = 8'hE0;
  localparam logic [7:0] BYTE_ED      = 8'hED;
  localparam logic [7:0] BYTE_F0      = 8'hF0;
  localparam logic [7:0] BYTE_F4      = 8'hF4;
  localparam logic [7:0] LO_AFTER_E0  = 8'hA0;
  localparam logic [7:0] HI_AFTER_ED  = 8'h9F;
  localparam logic [7:0] LO_AFTER_F0  = 8'h90;
  localparam logic [7:0] HI_AFTER_F4  = 8'h8F;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       eol;
    logic       last;
  } res_t;

endpackage

[rtl/core/utf8_validating_byte_escaper_core.sv]
// Top level of the UTF-8 validating byte escaper.
// Validates UTF-8 bytes, marks bytes for escaping and queues up to four results.
// Depends on u8esc_pkg.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_ready  in_byte, in_last
//   out_     output     out_valid/out_ready out_kind, out_byte, out_eol, out_last
//
// Each input transaction is classified in the cycle it is accepted and its results
// (zero to four) are written into a four-entry result buffer. The buffer drains one
// result per cycle while out_ready is high, so an item with one result is taken every
// cycle and an item with n results holds the input off until they have left. A new input
// transaction is taken when the buffer is empty or its last entry leaves in the same
// cycle. Reset is synchronous and clears the sequence state and the buffer.
module utf8_validating_byte_escaper_core
  import u8esc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_byte,
  output logic       out_eol,
  output logic       out_last
);

  logic [7:0]        lead_r, lead_nxt;
  logic [7:0]        cont_r [2];
  logic [7:0]        cont_nxt [2];
  logic [1:0]        held_r, held_nxt;
  logic [1:0]        need_r, need_nxt;
  logic              cr_r, cr_nxt;

  res_t              buf_r [MaxResults];
  logic [CountW-1:0] cnt_r;
  logic [IdxW-1:0]   rd_r;

  res_t              res_c [MaxResults];
  logic [CountW-1:0] n_c;
  logic              fresh_c;
  logic [7:0]        lo_c;
  logic [7:0]        hi_c;
  logic              in_acc;
  logic              out_acc;

  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (cnt_r == '0) || ((cnt_r == CountW'(1)) && out_ready);
  assign in_acc    = in_valid && in_ready;

  assign out_kind = buf_r[rd_r].kind;
  assign out_byte = buf_r[rd_r].data;
  assign out_eol  = buf_r[rd_r].eol;
  assign out_last = buf_r[rd_r].last;

  always_comb begin
    lo_c = BYTE_CONT_LO;
    hi_c = BYTE_CONT_HI;
    if (held_r == 2'd0) begin
      if (lead_r == BYTE_E0) begin
        lo_c = LO_AFTER_E0;
      end else if (lead_r == BYTE_ED) begin
        hi_c = HI_AFTER_ED;
      end else if (lead_r == BYTE_F0) begin
        lo_c = LO_AFTER_F0;
      end else if (lead_r == BYTE_F4) begin
        hi_c = HI_AFTER_F4;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MaxResults; i++) begin
      res_c[i] = '0;
    end
    n_c         = '0;
    fresh_c     = 1'b1;
    lead_nxt    = lead_r;
    cont_nxt[0] = cont_r[0];
    cont_nxt[1] = cont_r[1];
    held_nxt    = held_r;
    need_nxt    = need_r;
    cr_nxt      = cr_r;

    if (cr_r) begin
      cr_nxt = 1'b0;
      if (in_byte == BYTE_LF) begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: BYTE_CR, eol: 1'b0, last: 1'b0};
        n_c = n_c + CountW'(1);
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: BYTE_LF, eol: 1'b1, last: 1'b0};
        n_c = n_c + CountW'(1);
        fresh_c = 1'b0;
      end else begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: BYTE_CR, eol: 1'b1, last: 1'b0};
        n_c = n_c + CountW'(1);
      end
    end

    if (fresh_c && (need_r != 2'd0)) begin
      if ((in_byte >= lo_c) && (in_byte <= hi_c)) begin
        fresh_c = 1'b0;
        if (({1'b0, held_r} + 3'd1 >= {1'b0, need_r}) || (held_r >= 2'd2)) begin
          res_c[n_c[IdxW-1:0]] = '{kind: KIND_LIT, data: lead_r, eol: 1'b0, last: 1'b0};
          n_c = n_c + CountW'(1);
          if (held_r >= 2'd1) begin
            res_c[n_c[IdxW-1:0]] = '{kind: KIND_LIT, data: cont_r[0], eol: 1'b0, last: 1'b0};
            n_c = n_c + CountW'(1);
          end
          if (held_r >= 2'd2) begin
            res_c[n_c[IdxW-1:0]] = '{kind: KIND_LIT, data: cont_r[1], eol: 1'b0, last: 1'b0};
            n_c = n_c + CountW'(1);
          end
          res_c[n_c[IdxW-1:0]] = '{kind: KIND_LIT, data: in_byte, eol: 1'b0, last: 1'b0};
          n_c = n_c + CountW'(1);
          lead_nxt = '0;
          held_nxt = 2'd0;
          need_nxt = 2'd0;
        end else begin
          cont_nxt[held_r[0]] = in_byte;
          held_nxt = held_r + 2'd1;
        end
      end else begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: lead_r, eol: 1'b0, last: 1'b0};
        n_c = n_c + CountW'(1);
        if (held_r >= 2'd1) begin
          res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: cont_r[0], eol: 1'b0, last: 1'b0};
          n_c = n_c + CountW'(1);
        end
        if (held_r >= 2'd2) begin
          res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: cont_r[1], eol: 1'b0, last: 1'b0};
          n_c = n_c + CountW'(1);
        end
        lead_nxt = '0;
        held_nxt = 2'd0;
        need_nxt = 2'd0;
      end
    end

    if (fresh_c) begin
      if (in_byte == BYTE_CR) begin
        cr_nxt = 1'b1;
      end else if (in_byte == BYTE_LF) begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: BYTE_LF, eol: 1'b1, last: 1'b0};
        n_c = n_c + CountW'(1);
      end else if ((in_byte >= BYTE_SPACE) && (in_byte < BYTE_DEL)) begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_LIT, data: in_byte, eol: 1'b0, last: 1'b0};
        n_c = n_c + CountW'(1);
      end else if ((in_byte < BYTE_LEAD_LO) || (in_byte >= BYTE_BAD_LO)) begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: in_byte, eol: 1'b0, last: 1'b0};
        n_c = n_c + CountW'(1);
      end else begin
        lead_nxt = in_byte;
        held_nxt = 2'd0;
        if (in_byte <= BYTE_LEAD2HI) begin
          need_nxt = 2'd1;
        end else if (in_byte <= BYTE_LEAD3HI) begin
          need_nxt = 2'd2;
        end else begin
          need_nxt = 2'd3;
        end
      end
    end

    if (in_last) begin
      if (cr_nxt) begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: BYTE_CR, eol: 1'b1, last: 1'b0};
        n_c = n_c + CountW'(1);
      end
      if (need_nxt != 2'd0) begin
        res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: lead_nxt, eol: 1'b0, last: 1'b0};
        n_c = n_c + CountW'(1);
        if (held_nxt >= 2'd1) begin
          res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: cont_nxt[0], eol: 1'b0, last: 1'b0};
          n_c = n_c + CountW'(1);
        end
        if (held_nxt >= 2'd2) begin
          res_c[n_c[IdxW-1:0]] = '{kind: KIND_ESC, data: cont_nxt[1], eol: 1'b0, last: 1'b0};
          n_c = n_c + CountW'(1);
        end
      end
      lead_nxt = '0;
      held_nxt = 2'd0;
      need_nxt = 2'd0;
      cr_nxt   = 1'b0;
      if (n_c != '0) begin
        res_c[IdxW'(n_c - CountW'(1))].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= '0;
      held_r <= 2'd0;
      need_r <= 2'd0;
      cr_r   <= 1'b0;
    end else if (in_acc) begin
      lead_r <= lead_nxt;
      held_r <= held_nxt;
      need_r <= need_nxt;
      cr_r   <= cr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cont_r[0] <= cont_nxt[0];
      cont_r[1] <= cont_nxt[1];
      for (int i = 0; i < MaxResults; i++) begin
        buf_r[i] <= res_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= '0;
    end else if (in_acc) begin
      cnt_r <= n_c;
      rd_r  <= '0;
    end else if (out_acc) begin
      cnt_r <= cnt_r - CountW'(1);
      rd_r  <= rd_r + IdxW'(1);
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for utf8_validating_byte_escaper_core.
// Feeds directed and random byte messages, predicts the token stream and checks it.
// Depends on u8esc_pkg and the core RTL.
module tb_top;
  import u8esc_pkg::*;

  localparam int RandItems  = 400;
  localparam int CalmItems  = 60;
  localparam int StallLimit = 2000;
  localparam int ShowErrs   = 10;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
    logic       typed;
    logic       kind;
    logic       eol;
  } stim_row_t;

  logic       clk;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       out_eol;
  logic       out_last;

  utf8_validating_byte_escaper_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_eol   (out_eol),
    .out_last  (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the validator state.
  logic [7:0] pend_lead = 8'h00;
  logic [7:0] pend_cont [2];
  logic [1:0] cont_cnt  = 2'd0;
  logic [1:0] need_cnt  = 2'd0;
  logic       cr_pend   = 1'b0;

  res_t step_tok [MaxResults];
  int   step_n;
  res_t expected_tokens [$];

  stim_row_t  dir_tab [$];
  logic [7:0] msg_bytes [$];
  logic       row_typed = 1'b0;
  logic       row_kind  = KIND_LIT;
  logic       row_eol   = 1'b0;

  bit calm        = 1'b0;
  int tx_gap_pct  = 0;
  int rx_stall_pct = 0;
  int errs        = 0;
  int idle_cycles = 0;
  int n_in        = 0;
  int n_out       = 0;
  int n_esc       = 0;
  int n_eol       = 0;
  int n_msgs      = 0;

  task automatic push_token(input logic kind, input logic [7:0] data, input logic eol);
    if (step_n < MaxResults) begin
      step_tok[step_n].kind = kind;
      step_tok[step_n].data = data;
      step_tok[step_n].eol  = eol;
      step_tok[step_n].last = 1'b0;
      step_n++;
    end
  endtask

  task automatic flush_sequence();
    int i;
    push_token(KIND_ESC, pend_lead, 1'b0);
    for (i = 0; i < int'(cont_cnt) && i < 2; i++)
      push_token(KIND_ESC, pend_cont[i], 1'b0);
    pend_lead = 8'h00;
    cont_cnt  = 2'd0;
    need_cnt  = 2'd0;
  endtask

  task automatic start_fresh(input logic [7:0] b);
    if (b == BYTE_CR) begin
      cr_pend = 1'b1;
    end else if (b == BYTE_LF) begin
      push_token(KIND_ESC, b, 1'b1);
    end else if (b >= BYTE_SPACE && b < BYTE_DEL) begin
      push_token(KIND_LIT, b, 1'b0);
    end else if (b < BYTE_SPACE || b == BYTE_DEL || b < BYTE_LEAD_LO || b >= BYTE_BAD_LO) begin
      push_token(KIND_ESC, b, 1'b0);
    end else begin
      pend_lead = b;
      cont_cnt  = 2'd0;
      need_cnt  = (b <= BYTE_LEAD2HI) ? 2'd1 : (b <= BYTE_LEAD3HI) ? 2'd2 : 2'd3;
    end
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic lst);
    logic [7:0] lo;
    logic [7:0] hi;
    bit         done;
    int         i;
    step_n = 0;
    done   = 1'b0;
    if (cr_pend) begin
      cr_pend = 1'b0;
      if (b == BYTE_LF) begin
        push_token(KIND_ESC, BYTE_CR, 1'b0);
        push_token(KIND_ESC, BYTE_LF, 1'b1);
        done = 1'b1;
      end else begin
        push_token(KIND_ESC, BYTE_CR, 1'b1);
      end
    end
    if (!done && need_cnt != 2'd0) begin
      lo = BYTE_CONT_LO;
      hi = BYTE_CONT_HI;
      if (cont_cnt == 2'd0) begin
        if (pend_lead == BYTE_E0) lo = LO_AFTER_E0;
        else if (pend_lead == BYTE_ED) hi = HI_AFTER_ED;
        else if (pend_lead == BYTE_F0) lo = LO_AFTER_F0;
        else if (pend_lead == BYTE_F4) hi = HI_AFTER_F4;
      end
      if (b >= lo && b <= hi) begin
        if (int'(cont_cnt) + 1 >= int'(need_cnt) || cont_cnt >= 2'd2) begin
          push_token(KIND_LIT, pend_lead, 1'b0);
          for (i = 0; i < int'(cont_cnt) && i < 2; i++)
            push_token(KIND_LIT, pend_cont[i], 1'b0);
          push_token(KIND_LIT, b, 1'b0);
          pend_lead = 8'h00;
          cont_cnt  = 2'd0;
          need_cnt  = 2'd0;
        end else begin
          pend_cont[cont_cnt[0]] = b;
          cont_cnt = cont_cnt + 2'd1;
        end
        done = 1'b1;
      end else begin
        flush_sequence();
      end
    end
    if (!done)
      start_fresh(b);
    if (lst) begin
      if (cr_pend)
        push_token(KIND_ESC, BYTE_CR, 1'b1);
      if (need_cnt != 2'd0)
        flush_sequence();
      pend_lead = 8'h00;
      cont_cnt  = 2'd0;
      need_cnt  = 2'd0;
      cr_pend   = 1'b0;
      if (step_n > 0)
        step_tok[step_n - 1].last = 1'b1;
    end
  endtask

  task automatic note_error(input string msg);
    errs++;
    if (errs <= ShowErrs)
      $display("[%0t] ERROR: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    res_t t;
    res_t w;
    int   i;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        n_in++;
        predict_tokens(in_byte, in_last);
        if (row_typed) begin
          t.kind = row_kind;
          t.data = in_byte;
          t.eol  = row_eol;
          t.last = in_last;
          expected_tokens.push_back(t);
        end else begin
          for (i = 0; i < step_n; i++)
            expected_tokens.push_back(step_tok[i]);
        end
      end
      if (out_valid && out_ready) begin
        n_out++;
        if (out_kind === KIND_ESC) n_esc++;
        if (out_eol === 1'b1) n_eol++;
        if (expected_tokens.size() == 0) begin
          note_error($sformatf("unexpected token kind=%b byte=%02h eol=%b last=%b",
                               out_kind, out_byte, out_eol, out_last));
        end else begin
          w = expected_tokens.pop_front();
          if (out_kind !== w.kind || out_byte !== w.data || out_eol !== w.eol ||
              out_last !== w.last)
            note_error($sformatf({"token %0d: expected kind=%b byte=%02h eol=%b last=%b, ",
                                  "got kind=%b byte=%02h eol=%b last=%b"}, n_out,
                                 w.kind, w.data, w.eol, w.last,
                                 out_kind, out_byte, out_eol, out_last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Watchdog: no transaction for %0d cycles", StallLimit);
        $display("utf8_validating_byte_escaper_core test failed");
        $finish;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
        stall = $urandom_range(1, 15) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_row(input logic [7:0] b, input logic lst, input logic typed,
                         input logic kind, input logic eol);
    stim_row_t r;
    r.b     = b;
    r.lst   = lst;
    r.typed = typed;
    r.kind  = kind;
    r.eol   = eol;
    dir_tab.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input logic kind, input logic eol);
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    row_typed = typed;
    row_kind  = kind;
    row_eol   = eol;
    in_byte  <= b;
    in_last  <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    while (expected_tokens.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic build_message(input int target);
    int         pick;
    int         need;
    int         k;
    int         i;
    logic [7:0] lead;
    logic [7:0] lo;
    logic [7:0] hi;
    msg_bytes.delete();
    while (msg_bytes.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        msg_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 40) begin
        k = $urandom_range(0, 2);
        if (k != 1) msg_bytes.push_back(BYTE_CR);
        if (k != 0) msg_bytes.push_back(BYTE_LF);
      end else if (pick < 45) begin
        msg_bytes.push_back(($urandom_range(0, 3) == 0) ? BYTE_DEL
                                                         : 8'($urandom_range(0, 31)));
      end else if (pick < 93) begin
        if (pick < 60) lead = 8'($urandom_range(BYTE_LEAD_LO, BYTE_LEAD2HI));
        else if (pick < 73) lead = 8'($urandom_range(BYTE_E0, BYTE_LEAD3HI));
        else lead = 8'($urandom_range(BYTE_F0, BYTE_F4));
        need = (lead <= BYTE_LEAD2HI) ? 1 : (lead <= BYTE_LEAD3HI) ? 2 : 3;
        k = (pick >= 85) ? $urandom_range(0, need - 1) : need;
        lo = (lead == BYTE_E0) ? LO_AFTER_E0 : (lead == BYTE_F0) ? LO_AFTER_F0 : BYTE_CONT_LO;
        hi = (lead == BYTE_ED) ? HI_AFTER_ED : (lead == BYTE_F4) ? HI_AFTER_F4 : BYTE_CONT_HI;
        msg_bytes.push_back(lead);
        for (i = 0; i < k; i++) begin
          msg_bytes.push_back(8'($urandom_range(lo, hi)));
          lo = BYTE_CONT_LO;
          hi = BYTE_CONT_HI;
        end
        if (pick >= 85 && $urandom_range(0, 1) == 1)
          msg_bytes.push_back(($urandom_range(0, 1) == 1)
                              ? 8'($urandom_range(BYTE_CONT_LO, BYTE_CONT_HI))
                              : 8'($urandom()));
      end else begin
        msg_bytes.push_back(8'($urandom()));
      end
    end
  endtask

  initial begin
    int  n_rand;
    int  i;
    bit  mid_drained;
    n_rand      = 0;
    mid_drained = 1'b0;

    add_row(8'h41, 1'b0, 1'b1, KIND_LIT, 1'b0);
    add_row(8'h20, 1'b0, 1'b1, KIND_LIT, 1'b0);
    add_row(8'h7E, 1'b0, 1'b1, KIND_LIT, 1'b0);
    add_row(8'h00, 1'b0, 1'b1, KIND_ESC, 1'b0);
    add_row(8'h7F, 1'b0, 1'b1, KIND_ESC, 1'b0);
    add_row(8'hC1, 1'b0, 1'b1, KIND_ESC, 1'b0);
    add_row(8'hFF, 1'b0, 1'b1, KIND_ESC, 1'b0);
    add_row(8'hBF, 1'b0, 1'b1, KIND_ESC, 1'b0);
    add_row(8'h0D, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h0A, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h0A, 1'b0, 1'b1, KIND_ESC, 1'b1);
    add_row(8'h0D, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h41, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'hE0, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h9F, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'hED, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h9F, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'hF0, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h90, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'hC3, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'hF4, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h8F, 1'b0, 1'b0, KIND_LIT, 1'b0);
    add_row(8'h0D, 1'b1, 1'b0, KIND_LIT, 1'b0);
    add_row(8'hC2, 1'b1, 1'b1, KIND_ESC, 1'b0);
    add_row(8'h0D, 1'b1, 1'b1, KIND_ESC, 1'b1);
    add_row(8'h7E, 1'b1, 1'b1, KIND_LIT, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    tx_gap_pct   = 20;
    rx_stall_pct = 20;
    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].kind,
                dir_tab[i].eol);
    n_msgs = 4;
    in_valid <= 1'b0;
    wait_drain();

    while (n_rand < RandItems) begin
      calm = (n_rand >= RandItems - CalmItems);
      if (calm) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: tx_gap_pct = 0;
          1: tx_gap_pct = 8;
          default: tx_gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0: rx_stall_pct = 0;
          1: rx_stall_pct = 8;
          default: rx_stall_pct = 30;
        endcase
      end
      build_message($urandom_range(1, 24));
      for (i = 0; i < msg_bytes.size(); i++)
        send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, KIND_LIT, 1'b0);
      n_rand += msg_bytes.size();
      n_msgs++;
      if (!mid_drained && n_rand >= RandItems / 2) begin
        in_valid <= 1'b0;
        wait_drain();
        mid_drained = 1'b1;
      end
    end

    in_valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d bytes in %0d messages (%0d directed), checked %0d tokens.",
             n_in, n_msgs, dir_tab.size(), n_out);
    $display("Tokens marked for escaping: %0d, with end-of-line mark: %0d, mismatches: %0d.",
             n_esc, n_eol, errs);
    if (errs == 0)
      $display("utf8_validating_byte_escaper_core test passed");
    else
      $display("utf8_validating_byte_escaper_core test failed");
    $finish;
  end

endmodule
